>>> rtl/core/pn3d_pkg.sv
package pn3d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ONE_FX    = 1 << FRAC_BITS;
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = 8;

    typedef logic [TBL_AW-1:0]  t_byte;
    typedef logic signed [20:0] t_val;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // fade polynomial terms: 10 and 15 in 16.16, 6 as a plain integer factor
    localparam logic [19:0] FADE_K6  = 20'd6;
    localparam logic [19:0] FADE_K10 = 20'd655360;
    localparam logic [19:0] FADE_K15 = 20'd983040;

    localparam logic [16:0] OUT_MAX = 17'd65536;

endpackage

>>> rtl/core/perlin_noise_3d_unit.sv
// throughput: one evaluate item per cycle while o_stall is low; a write item gives no result
// a write waits while an evaluate item sits in the first table lookup stage
// the hash chain is three dependent table lookups, each a registered ram read
// reset: synchronous, clears pipeline valids, output and skid valids and table entry flags;
// the table reads as the identity until an entry is written
module perlin_noise_3d_unit
    import pn3d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [7:0]         i_entry_index,
    input  logic [7:0]         i_entry_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [16:0]        o_noise_value
);

    function automatic t_val grad(input logic [3:0] h, input logic signed [16:0] x,
                                  input logic signed [16:0] y, input logic signed [16:0] z);
        t_val u;
        t_val v;
        t_val xe;
        t_val ye;
        t_val ze;
        xe = t_val'(x);
        ye = t_val'(y);
        ze = t_val'(z);
        u = (h < 4'd8) ? xe : ye;
        if (h < 4'd4) begin
            v = ye;
        end else if (h == 4'd12 || h == 4'd14) begin
            v = xe;
        end else begin
            v = ze;
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [39:0] fx_prod(input logic [16:0] f, input t_val a,
                                                   input t_val b);
        logic signed [17:0] fs;
        logic signed [21:0] d;
        fs = signed'({1'b0, f});
        d  = 22'(b) - 22'(a);
        return 40'(fs) * 40'(d);
    endfunction

    // fixed point product scaled back, truncated toward zero
    function automatic t_val fx_trunc(input logic signed [39:0] p);
        logic signed [39:0] q;
        q = p + (p[39] ? 40'(ONE_FX - 1) : 40'sd0);
        return t_val'(q >>> FRAC_BITS);
    endfunction

    logic        en;
    logic        acc;
    logic        wr_acc;
    logic        ev_acc;
    logic [11:1] r_v;

    logic [31:0] pos  [3];
    logic [15:0] frac [3];
    logic [19:0] fm   [3];
    logic [16:0] fade [3];

    logic [TBL_DEPTH-1:0] r_tbl_vld;
    t_byte       rd_adr   [14];
    t_byte       rd_dout  [14];
    t_byte       r_lk_adr [14];
    logic [13:0] r_lk_vld;
    t_byte       hv       [14];

    t_byte       r_cy1;
    t_byte       r_cz1;
    t_byte       r_cz2;
    logic [15:0] r_fr1 [3];
    logic [15:0] r_fr2 [3];
    logic [15:0] r_fr3 [3];

    logic [31:0] r_ptt   [3];
    logic [35:0] r_ptm   [3];
    logic [31:0] r_pt3   [3];
    logic [19:0] r_inner [3];
    logic [35:0] r_pf    [3];
    logic [16:0] r_fd4   [3];

    t_val               r_g4  [8];
    t_val               r_lb5 [4];
    logic signed [39:0] r_lp5 [4];
    t_val               r_l6  [4];
    t_val               r_mb7 [2];
    logic signed [39:0] r_mp7 [2];
    t_val               r_m8  [2];
    t_val               r_nb9;
    logic signed [39:0] r_np9;
    t_val               r_n10;
    logic [16:0]        r_res11;
    logic [16:0]        r_fv5;
    logic [16:0]        r_fv6;
    logic [16:0]        r_fw5;
    logic [16:0]        r_fw6;
    logic [16:0]        r_fw7;
    logic [16:0]        r_fw8;

    logic signed [21:0] n_sum;
    logic [20:0]        n_half;
    logic [16:0]        n_res;

    logic        r_out_v;
    logic [16:0] r_out;
    logic        r_skid_v;
    logic [16:0] r_skid;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v || (i_valid && (i_cmd == CMD_WRITE) && r_v[1]);
    assign acc     = i_valid && !o_stall;
    assign wr_acc  = acc && (i_cmd == CMD_WRITE);
    assign ev_acc  = acc && (i_cmd == CMD_EVAL);

    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            frac[a] = pos[a][15:0];
            fm[a]   = FADE_K15 - FADE_K6 * {4'd0, frac[a]};
            fade[a] = r_pf[a][32:16];
        end
    end

    // table lookups: entry not yet written reads as its own index
    always_comb begin
        for (int p = 0; p < 14; p++) begin
            hv[p] = r_lk_vld[p] ? rd_dout[p] : r_lk_adr[p];
        end
        rd_adr[0] = pos[0][23:16];
        rd_adr[1] = pos[0][23:16] + 8'd1;
        for (int i = 0; i < 2; i++) begin
            rd_adr[2 + 2*i] = hv[i] + r_cy1;
            rd_adr[3 + 2*i] = hv[i] + r_cy1 + 8'd1;
        end
        for (int j = 0; j < 4; j++) begin
            rd_adr[6 + 2*j] = hv[2 + j] + r_cz2;
            rd_adr[7 + 2*j] = hv[2 + j] + r_cz2 + 8'd1;
        end
    end

    for (genvar r = 0; r < 7; r++) begin : g_tbl
        pn3d_ram #(
            .WIDTH (TBL_AW),
            .DEPTH (TBL_DEPTH)
        ) u_ram (
            .i_clk    (i_clk),
            .i_we     (wr_acc),
            .i_waddr  (i_entry_index),
            .i_wdata  (i_entry_value),
            .i_re     (en),
            .i_raddr0 (rd_adr[2*r]),
            .i_raddr1 (rd_adr[2*r + 1]),
            .o_rdata0 (rd_dout[2*r]),
            .o_rdata1 (rd_dout[2*r + 1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
            r_v       <= '0;
        end else begin
            if (wr_acc) begin
                r_tbl_vld[i_entry_index] <= 1'b1;
            end
            if (en) begin
                r_v <= {r_v[10:1], ev_acc};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 14; p++) begin
                r_lk_adr[p] <= rd_adr[p];
                r_lk_vld[p] <= r_tbl_vld[rd_adr[p]];
            end
            r_cy1 <= pos[1][23:16];
            r_cz1 <= pos[2][23:16];
            r_cz2 <= r_cz1;

            // fade 6t^5-15t^4+10t^3 over three multiply stages
            for (int a = 0; a < 3; a++) begin
                r_fr1[a]   <= frac[a];
                r_fr2[a]   <= r_fr1[a];
                r_fr3[a]   <= r_fr2[a];
                r_ptt[a]   <= 32'(frac[a]) * 32'(frac[a]);
                r_ptm[a]   <= 36'(frac[a]) * 36'(fm[a]);
                r_pt3[a]   <= 32'(r_ptt[a][31:16]) * 32'(r_fr1[a]);
                r_inner[a] <= FADE_K10 - r_ptm[a][35:16];
                r_pf[a]    <= 36'(r_pt3[a][31:16]) * 36'(r_inner[a]);
                r_fd4[a]   <= fade[a];
            end

            // corner k: bit 2 selects x-1, bit 1 y-1, bit 0 z-1
            for (int k = 0; k < 8; k++) begin
                r_g4[k] <= grad(hv[6 + k][3:0],
                                signed'({k[2] ? 1'b1 : 1'b0, r_fr3[0]}),
                                signed'({k[1] ? 1'b1 : 1'b0, r_fr3[1]}),
                                signed'({k[0] ? 1'b1 : 1'b0, r_fr3[2]}));
            end

            for (int k = 0; k < 4; k++) begin
                r_lb5[k] <= r_g4[k];
                r_lp5[k] <= fx_prod(r_fd4[0], r_g4[k], r_g4[k + 4]);
                r_l6[k]  <= r_lb5[k] + fx_trunc(r_lp5[k]);
            end
            r_fv5 <= r_fd4[1];
            r_fv6 <= r_fv5;
            r_fw5 <= r_fd4[2];
            r_fw6 <= r_fw5;
            r_fw7 <= r_fw6;
            r_fw8 <= r_fw7;

            for (int z = 0; z < 2; z++) begin
                r_mb7[z] <= r_l6[z];
                r_mp7[z] <= fx_prod(r_fv6, r_l6[z], r_l6[z + 2]);
                r_m8[z]  <= r_mb7[z] + fx_trunc(r_mp7[z]);
            end

            r_nb9   <= r_m8[0];
            r_np9   <= fx_prod(r_fw8, r_m8[0], r_m8[1]);
            r_n10   <= r_nb9 + fx_trunc(r_np9);
            r_res11 <= n_res;
        end
    end

    // (n + 1) / 2 into unsigned 1.16 with saturation
    always_comb begin
        n_sum  = 22'(r_n10) + 22'(ONE_FX);
        n_half = n_sum[21:1];
        if (n_sum <= 22'sd0) begin
            n_res = '0;
        end else if (n_half > 21'(OUT_MAX)) begin
            n_res = OUT_MAX;
        end else begin
            n_res = n_half[16:0];
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r_v[11];
            end
        end else if (en && r_v[11]) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : r_res11;
        end else if (en && r_v[11]) begin
            r_skid <= r_res11;
        end
    end

    assign o_valid       = r_out_v;
    assign o_noise_value = r_out;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds an item while output register is empty");

    a_eval_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_EVAL) |=> r_v[1])
        else $error("accepted evaluate item missing from first stage");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_v[11] && r_out_v && i_stall))
        else $error("skid filled without a stalled result and a finished item");
`endif

endmodule

>>> rtl/core/pn3d_ram.sv
module pn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= mem[i_raddr0];
            r_rdata1 <= mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

>>> verif/perlin_noise_3d_unit_tb.sv
`timescale 1ns / 100ps

module perlin_noise_3d_unit_tb
    import pn3d_pkg::*;
();

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_cmd;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_pos_z;
    logic [7:0]         i_entry_index;
    logic [7:0]         i_entry_value;
    logic               o_valid;
    logic               i_stall;
    logic [16:0]        o_noise_value;

    perlin_noise_3d_unit DUT (.*);

    logic [7:0]  perm_model [TBL_DEPTH];
    logic [16:0] noise_queue [$];
    int          mismatch_count;
    int          burst_left;
    int          stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p / 65536;
    endfunction

    function automatic longint fx_lerp(longint t, longint a, longint b);
        return a + fx_mul(t, b - a);
    endfunction

    function automatic longint fade_curve(longint t);
        longint inner;
        longint t3;
        inner = fx_mul(t, t * 6 - 15 * 65536) + 10 * 65536;
        t3 = fx_mul(fx_mul(t, t), t);
        return fx_mul(t3, inner);
    endfunction

    function automatic longint grad_dot(int unsigned hsh, longint x, longint y, longint z);
        int unsigned h;
        longint u;
        longint v;
        h = hsh & 15;
        u = (h < 8) ? x : y;
        v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function automatic int unsigned perm_at(int unsigned i);
        return perm_model[i % TBL_DEPTH];
    endfunction

    function automatic void split_pos(logic signed [31:0] raw, output int unsigned cell_idx,
                                      output longint frac);
        longint v;
        longint c;
        v = raw;
        frac = raw[15:0];
        c = (v - frac) / 65536;
        c = c % TBL_DEPTH;
        if (c < 0) c += TBL_DEPTH;
        cell_idx = 32'(c);
    endfunction

    function automatic logic [16:0] noise_at(logic signed [31:0] px, logic signed [31:0] py,
                                             logic signed [31:0] pz);
        int unsigned cx, cy, cz, a, aa, ab, b, ba, bb;
        longint x, y, z, fu, fv, fw, x1, y1, z1, l0, l1, l2, l3, n, s;
        split_pos(px, cx, x);
        split_pos(py, cy, y);
        split_pos(pz, cz, z);
        fu = fade_curve(x);
        fv = fade_curve(y);
        fw = fade_curve(z);
        a = perm_at(cx) + cy;
        aa = perm_at(a) + cz;
        ab = perm_at(a + 1) + cz;
        b = perm_at(cx + 1) + cy;
        ba = perm_at(b) + cz;
        bb = perm_at(b + 1) + cz;
        x1 = x - 65536;
        y1 = y - 65536;
        z1 = z - 65536;
        l0 = fx_lerp(fu, grad_dot(perm_at(aa), x, y, z), grad_dot(perm_at(ba), x1, y, z));
        l1 = fx_lerp(fu, grad_dot(perm_at(ab), x, y1, z), grad_dot(perm_at(bb), x1, y1, z));
        l2 = fx_lerp(fu, grad_dot(perm_at(aa + 1), x, y, z1),
                     grad_dot(perm_at(ba + 1), x1, y, z1));
        l3 = fx_lerp(fu, grad_dot(perm_at(ab + 1), x, y1, z1),
                     grad_dot(perm_at(bb + 1), x1, y1, z1));
        n = fx_lerp(fw, fx_lerp(fv, l0, l1), fx_lerp(fv, l2, l3));
        s = n + 65536;
        if (s <= 0) return 17'd0;
        s = s >> 1;
        if (s > OUT_MAX) s = OUT_MAX;
        return s[16:0];
    endfunction

    task automatic report_mismatch(logic [16:0] got, logic [16:0] want);
        mismatch_count++;
        $display("mismatch at %0t: noise_value got %0d want %0d", $realtime, got, want);
    endtask

    // sender gaps come between bursts of random length
    task automatic send_item(logic cmd, logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic [7:0] idx, logic [7:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_entry_index <= idx;
        i_entry_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (cmd == CMD_WRITE) perm_model[idx] = val;
        else noise_queue.push_back(noise_at(px, py, pz));
        @(negedge i_clk);
    endtask

    task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [31:0] pz);
        send_item(CMD_EVAL, px, py, pz, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_write(logic [7:0] idx, logic [7:0] val);
        send_item(CMD_WRITE, $urandom, $urandom, $urandom, idx, val);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        while (noise_queue.size() != 0) @(negedge i_clk);
        repeat (15) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (noise_queue.size() == 0) begin
                mismatch_count++;
                $display("unexpected result at %0t: %0d", $realtime, o_noise_value);
            end else begin
                logic [16:0] want;
                want = noise_queue.pop_front();
                if (o_noise_value !== want) report_mismatch(o_noise_value, want);
            end
        end
    end

    // receiver stall pattern: off, random, or long runs
    always @(negedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    task automatic test_identity_points();
        send_point(32'sd0, 32'sd0, 32'sd0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_FFFF);
        send_point(32'sh0000_8000, 32'sh0001_4000, 32'sh0002_C000);
        send_point(-32'sh0000_8000, -32'sh0001_4000, -32'sh00FF_C000);
        send_point(32'sh00FF_FFFF, 32'sh0100_0000, 32'sh0101_0001);
        send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0);
    endtask

    task automatic test_table_writes();
        send_write(8'd0, 8'd255);
        send_write(8'd255, 8'd0);
        send_point(32'sh0000_4000, 32'sh0000_C000, 32'sh0000_2000);
        send_point(32'shFFFF_4000, 32'shFFFF_C000, 32'sh00FF_2000);
        send_write(8'd1, 8'd17);
        send_point(32'sh0001_1234, 32'sh0000_8765, 32'sh0000_FFFF);
        send_write(8'd1, 8'd1);
        send_point(32'sh0001_1234, 32'sh0000_8765, 32'sh0000_FFFF);
    endtask

    task automatic test_random_mix(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_write(8'($urandom), 8'($urandom));
            end else begin
                case ($urandom_range(0, 2))
                    0: send_point($urandom, $urandom, $urandom);
                    1: send_point($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                                  $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                                  $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
                    default: send_point({$urandom_range(0, 3) << 16} | $urandom_range(0, 65535),
                                        $urandom, {16'hFFFF, 16'($urandom)});
                endcase
            end
        end
    endtask

    task automatic test_pause_drain();
        send_point(32'sh0003_3333, 32'sh0004_4444, 32'sh0005_5555);
        wait_drained();
        send_write(8'd3, 8'd200);
        send_point(32'sh0003_3333, 32'sh0004_4444, 32'sh0005_5555);
    endtask

    initial begin
        mismatch_count = 0;
        burst_left = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = CMD_EVAL;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_entry_index = '0;
        i_entry_value = '0;
        for (int k = 0; k < TBL_DEPTH; k++) perm_model[k] = k[7:0];
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_identity_points();
        test_table_writes();
        test_pause_drain();
        test_random_mix(330);
        wait_drained();
        test_random_mix(320);
        wait_drained();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
